// ----- rtl/core/fsd_pkg.sv -----
package fsd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 9;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned MAX_PACKET  = 32;

  // fixed sentence layout
  localparam logic [POS_W-1:0] POS_TALKER   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_RECEIVER = POS_W'(2);
  localparam logic [POS_W-1:0] POS_SIZE     = POS_W'(3);
  localparam logic [POS_W-1:0] POS_HEADER   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_DATA_ID  = POS_W'(5);
  localparam logic [POS_W-1:0] POS_DATA0    = POS_W'(6);
  localparam logic [POS_W-1:0] END_OFFSET   = POS_W'(4);

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd36;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd10;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_OK       = 2'd1,
    KIND_NO_START = 2'd2,
    KIND_BAD_END  = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MARKER = 2'd0,
    CFG_END_MARKER   = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              first_of_sentence;
  } in_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [IDX_W-1:0]  payload_index;
    logic [BYTE_W-1:0] talker;
    logic [BYTE_W-1:0] receiver;
    logic [BYTE_W-1:0] size_field;
    logic [BYTE_W-1:0] header_byte;
    logic [BYTE_W-1:0] data_kind_id;
    logic              sentence_done;
  } out_item_t;

  typedef struct packed {
    logic              we;
    cfg_reg_e          idx;
    logic [BYTE_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic      hit;
    out_item_t item;
  } parse_res_t;

endpackage

// ----- rtl/core/fsd_in_stage.sv -----
module fsd_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  fsd_pkg::in_item_t data_i,
  output logic             valid_o,
  output fsd_pkg::in_item_t data_o,
  input  logic             advance_i
);
  import fsd_pkg::*;

  logic     valid_q, valid_d;
  in_item_t data_q;
  logic     load;

  assign ready_o = !valid_q || advance_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/fsd_parser.sv -----
module fsd_parser #(
  parameter int unsigned MaxPacket = fsd_pkg::MAX_PACKET
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fsd_pkg::cfg_wr_t    cfg_i,
  input  logic                valid_i,
  input  fsd_pkg::in_item_t   item_i,
  input  logic                fire_i,
  output fsd_pkg::parse_res_t res_o
);
  import fsd_pkg::*;

  // last position whose data byte is still forwarded
  localparam logic [POS_W-1:0] LastDataPos = POS_W'(MaxPacket + 4);

  logic [BYTE_W-1:0] start_marker_q, end_marker_q;
  logic              in_sentence_q, in_sentence_d;
  logic [POS_W-1:0]  position_q, position_d;
  logic [BYTE_W-1:0] talker_q, talker_d;
  logic [BYTE_W-1:0] receiver_q, receiver_d;
  logic [BYTE_W-1:0] size_q, size_d;
  logic [BYTE_W-1:0] header_q, header_d;
  logic [BYTE_W-1:0] data_id_q, data_id_d;
  logic [POS_W-1:0]  end_pos;
  logic [POS_W-1:0]  data_idx;
  logic [BYTE_W-1:0] b;

  assign b        = item_i.rx_byte;
  assign end_pos  = POS_W'(size_d) + END_OFFSET;
  assign data_idx = position_q - POS_DATA0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= START_MARKER_RST;
      end_marker_q   <= END_MARKER_RST;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_START_MARKER: start_marker_q <= cfg_i.data;
        CFG_END_MARKER:   end_marker_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_sentence_d = in_sentence_q;
    position_d    = position_q;
    talker_d      = talker_q;
    receiver_d    = receiver_q;
    size_d        = size_q;
    header_d      = header_q;
    data_id_d     = data_id_q;
    res_o         = '0;

    if (item_i.first_of_sentence) begin
      talker_d   = '0;
      receiver_d = '0;
      size_d     = '0;
      header_d   = '0;
      data_id_d  = '0;
      if (b != start_marker_q) begin
        in_sentence_d            = 1'b0;
        position_d               = '0;
        res_o.hit                = 1'b1;
        res_o.item.kind          = KIND_NO_START;
        res_o.item.sentence_done = 1'b1;
      end else begin
        in_sentence_d = 1'b1;
        position_d    = POS_TALKER;
      end
    end else if (in_sentence_q) begin
      if (position_q == POS_TALKER)   talker_d   = b;
      if (position_q == POS_RECEIVER) receiver_d = b;
      if (position_q == POS_SIZE)     size_d     = b;
      if (position_q == POS_HEADER)   header_d   = b;
      if (position_q == POS_DATA_ID)  data_id_d  = b;

      if (position_q >= POS_HEADER && position_q == end_pos) begin
        // end byte: close the sentence with a status beat
        in_sentence_d            = 1'b0;
        position_d               = '0;
        res_o.hit                = 1'b1;
        res_o.item.kind          = (b == end_marker_q) ? KIND_OK : KIND_BAD_END;
        res_o.item.talker        = talker_d;
        res_o.item.receiver      = receiver_d;
        res_o.item.size_field    = size_d;
        res_o.item.header_byte   = header_d;
        res_o.item.data_kind_id  = data_id_d;
        res_o.item.sentence_done = 1'b1;
      end else begin
        position_d = position_q + POS_W'(1);
        if (position_q >= POS_DATA0 && position_q < end_pos &&
            position_q <= LastDataPos) begin
          res_o.hit                = 1'b1;
          res_o.item.kind          = KIND_DATA;
          res_o.item.payload_byte  = b;
          res_o.item.payload_index = data_idx[IDX_W-1:0];
        end
      end
    end

    if (!valid_i) begin
      res_o.hit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sentence_q <= 1'b0;
      position_q    <= '0;
      talker_q      <= '0;
      receiver_q    <= '0;
      size_q        <= '0;
      header_q      <= '0;
      data_id_q     <= '0;
    end else if (fire_i) begin
      in_sentence_q <= in_sentence_d;
      position_q    <= position_d;
      talker_q      <= talker_d;
      receiver_q    <= receiver_d;
      size_q        <= size_d;
      header_q      <= header_d;
      data_id_q     <= data_id_d;
    end
  end

endmodule

// ----- rtl/core/fsd_out_stage.sv -----
module fsd_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  fsd_pkg::out_item_t data_i,
  output logic               free_o,
  output logic               valid_o,
  input  logic               ready_i,
  output fsd_pkg::out_item_t data_o
);
  import fsd_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/framed_sentence_deframer.sv -----
// channel | direction | handshake                     | payload
// --------+-----------+-------------------------------+----------------------------
// in      | sink      | in_valid_i / in_ready_o       | in_data_i (rx byte, first flag)
// out     | source    | out_valid_o / out_ready_i     | out_data_o (kind, data, header)
// cfg     | sink      | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// one byte per cycle sustained unless a result waits on a stalled output register; an
// item is held in the input register and its result, if any, is loaded into the output
// register when it moves on; position counter and compares sit in one stage
// bytes with no result drain even while the output register is stalled
// reset clears position, hunt state, held header and both markers to defaults
// cfg writes are always ready and take effect on the next edge
module framed_sentence_deframer #(
  parameter int unsigned MaxPacket = fsd_pkg::MAX_PACKET
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  fsd_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output fsd_pkg::out_item_t                 out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fsd_pkg::BYTE_W-1:0]         cfg_data_i
);
  import fsd_pkg::*;

  logic       stage_valid;
  in_item_t   stage_item;
  logic       advance;
  logic       slot_free;
  cfg_wr_t    cfg_wr;
  parse_res_t res;

  // config port never stalls
  assign cfg_ready_o = 1'b1;
  assign cfg_wr.we   = cfg_valid_i;
  assign cfg_wr.idx  = cfg_reg_e'(cfg_index_i);
  assign cfg_wr.data = cfg_data_i;

  // a staged beat moves on when it yields nothing or the output slot frees up
  assign advance = stage_valid && (!res.hit || slot_free);

  fsd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .data_i    (in_data_i),
    .valid_o   (stage_valid),
    .data_o    (stage_item),
    .advance_i (advance)
  );

  fsd_parser #(
    .MaxPacket (MaxPacket)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_wr),
    .valid_i (stage_valid),
    .item_i  (stage_item),
    .fire_i  (advance),
    .res_o   (res)
  );

  fsd_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res.hit),
    .data_i  (res.item),
    .free_o  (slot_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  // status beats and only status beats close a sentence
  a_done_matches_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.sentence_done == (out_data_o.kind != KIND_DATA)))
    else $error("sentence_done disagrees with kind");

  // data and missing-start beats carry no header
  a_no_header_on_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_DATA || out_data_o.kind == KIND_NO_START)
    |-> (out_data_o.talker == '0 && out_data_o.size_field == '0))
    else $error("header fields leaked onto a non-status beat");

  // a result never overwrites a beat still waiting downstream
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.hit) |-> slot_free)
    else $error("result loaded into an occupied output register");

  // a staged beat that cannot move stays put
  a_stage_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid && !advance) |=> (stage_valid && $stable(stage_item)))
    else $error("staged beat lost while stalled");

endmodule
